// ===== design/frt_pkg.sv =====
// frt_pkg: shared types and constants of the fragment reassembly tracker.
// Used by frt_front, frt_back and the top level; depends on nothing.
package frt_pkg;

    localparam int unsigned HEADER_BYTES    = 12;
    localparam int unsigned MAX_FRAGMENTS   = 64;
    localparam int unsigned MIN_TOTAL_BYTES = 4;

    // status codes
    localparam logic [3:0] ST_NEW      = 4'd0;
    localparam logic [3:0] ST_DUP      = 4'd1;
    localparam logic [3:0] ST_SHORT    = 4'd2;
    localparam logic [3:0] ST_OVER_MTU = 4'd3;
    localparam logic [3:0] ST_TINY     = 4'd4;
    localparam logic [3:0] ST_OFF_END  = 4'd5;
    localparam logic [3:0] ST_MISALIGN = 4'd6;
    localparam logic [3:0] ST_PAY_END  = 4'd7;
    localparam logic [3:0] ST_SIZE     = 4'd8;
    localparam logic [3:0] ST_TOO_MANY = 4'd9;

    // configuration register indexes
    localparam logic REG_MTU     = 1'b0;
    localparam logic REG_MAX_MSG = 1'b1;

    typedef struct packed {
        logic [15:0] frag_bytes;
        logic [31:0] message_id;
        logic [15:0] message_bytes;
        logic [15:0] byte_offset;
        logic [63:0] now_time;
    } frag_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        complete;
        logic        ack_now;
        logic [6:0]  missing_count;
        logic [63:0] missing_bits;
        logic [31:0] ack_id;
    } result_t;

    // classified word passed from front to back
    typedef struct packed {
        logic [3:0]  status;      // header error or ST_NEW
        logic [31:0] message_id;
        logic [15:0] message_bytes;
        logic [63:0] now_time;
        logic [5:0]  frag_bit;
        logic [15:0] frag_count;  // ceil(frag_bytes / payload)
        logic [6:0]  msg_frags;   // ceil(message_bytes / payload), valid if !too_many
        logic        too_many;
    } job_t;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

    typedef enum logic [2:0] {B_IDLE, B_WALK, B_DECIDE, B_COUNT, B_OUT} back_state_t;

endpackage

// ===== design/frt_fifo.sv =====
// frt_fifo: small synchronous queue for words of any packed type.
// No dependencies.
module frt_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  T     din,
    input  logic pop,
    output logic empty,
    output T     dout
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== design/frt_front.sv =====
// frt_front: accepts fragment headers, runs the header checks and the
// divisions by the payload size (one quotient bit per cycle). Uses frt_pkg.
module frt_front
    import frt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] mtu_bytes,
    input  logic        push,
    output logic        full,
    input  frag_t       frag,
    input  logic        job_full,
    output logic        job_push,
    output job_t        job
);
    front_state_t state_reg, state_next;
    frag_t        item_reg, item_next;
    logic [15:0]  pay_reg, pay_next;
    logic [3:0]   status_reg, status_next;
    logic [3:0]   step_reg, step_next;
    logic [15:0]  q_off_reg, q_off_next, q_frag_reg, q_frag_next, q_msg_reg, q_msg_next;
    logic [15:0]  r_off_reg, r_off_next, r_frag_reg, r_frag_next, r_msg_reg, r_msg_next;
    logic [15:0]  pay_in;
    logic [3:0]   pre_status;
    logic [16:0]  end_bytes;
    logic [15:0]  msg_n;
    logic [3:0]   fin_status;

    // one restoring step: returns {remainder, quotient/dividend}
    function automatic logic [31:0] div_step(input logic [15:0] r, input logic [15:0] q,
                                             input logic [15:0] p);
        logic [16:0] rs;
        rs = {r, q[15]};
        if (rs >= {1'b0, p})
        begin
            rs = rs - {1'b0, p};
            return {rs[15:0], q[14:0], 1'b1};
        end
        return {rs[15:0], q[14:0], 1'b0};
    endfunction

    assign full = (state_reg != F_IDLE);

    always_comb
    begin
        pay_in = (mtu_bytes > 16'(HEADER_BYTES)) ? mtu_bytes - 16'(HEADER_BYTES) : 16'd1;
        if (frag.frag_bytes < 16'(HEADER_BYTES))
        begin
            pre_status = ST_SHORT;
        end
        else if (frag.frag_bytes > mtu_bytes)
        begin
            pre_status = ST_OVER_MTU;
        end
        else if (frag.message_bytes < 16'(MIN_TOTAL_BYTES))
        begin
            pre_status = ST_TINY;
        end
        else if (frag.byte_offset >= frag.message_bytes)
        begin
            pre_status = ST_OFF_END;
        end
        else
        begin
            pre_status = ST_NEW;
        end

        end_bytes = {1'b0, item_reg.byte_offset} + {1'b0, item_reg.frag_bytes}
                    - 17'(HEADER_BYTES);
        msg_n = q_msg_reg + {15'd0, (r_msg_reg != '0)};
        if (status_reg != ST_NEW)
        begin
            fin_status = status_reg;
        end
        else if (r_off_reg != '0)
        begin
            fin_status = ST_MISALIGN;
        end
        else if (end_bytes > {1'b0, item_reg.message_bytes})
        begin
            fin_status = ST_PAY_END;
        end
        else
        begin
            fin_status = ST_NEW;
        end

        job.status        = fin_status;
        job.message_id    = item_reg.message_id;
        job.message_bytes = item_reg.message_bytes;
        job.now_time      = item_reg.now_time;
        job.frag_bit      = q_off_reg[5:0];
        job.frag_count    = q_frag_reg + {15'd0, (r_frag_reg != '0)};
        job.msg_frags     = msg_n[6:0];
        job.too_many      = (msg_n > 16'(MAX_FRAGMENTS));

        state_next  = state_reg;
        item_next   = item_reg;
        pay_next    = pay_reg;
        status_next = status_reg;
        step_next   = step_reg;
        q_off_next  = q_off_reg;
        q_frag_next = q_frag_reg;
        q_msg_next  = q_msg_reg;
        r_off_next  = r_off_reg;
        r_frag_next = r_frag_reg;
        r_msg_next  = r_msg_reg;
        job_push    = 1'b0;

        case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    item_next   = frag;
                    pay_next    = pay_in;
                    status_next = pre_status;
                    step_next   = '0;
                    q_off_next  = frag.byte_offset;
                    q_frag_next = frag.frag_bytes;
                    q_msg_next  = frag.message_bytes;
                    r_off_next  = '0;
                    r_frag_next = '0;
                    r_msg_next  = '0;
                    state_next  = (pre_status == ST_NEW) ? F_DIV : F_PUSH;
                end
            end
            F_DIV:
            begin
                {r_off_next, q_off_next}   = div_step(r_off_reg, q_off_reg, pay_reg);
                {r_frag_next, q_frag_next} = div_step(r_frag_reg, q_frag_reg, pay_reg);
                {r_msg_next, q_msg_next}   = div_step(r_msg_reg, q_msg_reg, pay_reg);
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd15)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!job_full)
                begin
                    job_push   = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        pay_reg    <= pay_next;
        status_reg <= status_next;
        step_reg   <= step_next;
        q_off_reg  <= q_off_next;
        q_frag_reg <= q_frag_next;
        q_msg_reg  <= q_msg_next;
        r_off_reg  <= r_off_next;
        r_frag_reg <= r_frag_next;
        r_msg_reg  <= r_msg_next;
    end

endmodule

// ===== design/frt_back.sv =====
// frt_back: reassembly table. Walks the entries one per cycle for lookup,
// id ordering and eviction choice, updates the bitmap, counts it. Uses frt_pkg.
module frt_back
    import frt_pkg::*;
#(
    parameter int TABLE_DEPTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] max_messages,
    input  logic       job_empty,
    output logic       job_pop,
    input  job_t       job,
    input  logic       res_full,
    output logic       res_push,
    output result_t    res
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    back_state_t state_reg, state_next;

    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [31:0] id_reg    [TABLE_DEPTH];
    logic [31:0] id_next   [TABLE_DEPTH];
    logic [15:0] total_reg [TABLE_DEPTH];
    logic [15:0] total_next[TABLE_DEPTH];
    logic [63:0] map_reg   [TABLE_DEPTH];
    logic [63:0] map_next  [TABLE_DEPTH];
    logic [63:0] touch_reg [TABLE_DEPTH];
    logic [63:0] touch_next[TABLE_DEPTH];
    logic [IW-1:0] rank_reg [TABLE_DEPTH];
    logic [IW-1:0] rank_next[TABLE_DEPTH];
    logic [CW-1:0] in_use_reg, in_use_next;

    job_t    job_reg, job_next;
    result_t res_reg, res_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] larger_reg, larger_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [15:0]   hit_total_reg, hit_total_next;
    logic [63:0]   hit_map_reg, hit_map_next;
    logic          old_found_reg, old_found_next;
    logic [IW-1:0] old_idx_reg, old_idx_next;
    logic [63:0]   old_time_reg, old_time_next;
    logic [IW-1:0] old_rank_reg, old_rank_next;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [2:0]    chunk_reg, chunk_next;

    logic [CW-1:0] limit;
    logic          evict, dup, v_after;
    logic [IW-1:0] tgt;
    logic [63:0]   new_map, cur_map, upd_map;
    logic [IW-1:0] rk;
    logic [7:0]    chunk_bits;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int b = 0; b < 8; b++)
        begin
            c = c + {3'd0, v[b]};
        end
        return c;
    endfunction

    assign res = res_reg;

    always_comb
    begin
        if (max_messages == '0)
        begin
            limit = CW'(1);
        end
        else if (32'(max_messages) > TABLE_DEPTH)
        begin
            limit = CW'(TABLE_DEPTH);
        end
        else
        begin
            limit = CW'(max_messages);
        end

        evict = !hit_reg && (in_use_reg >= limit) && old_found_reg;
        if (hit_reg)
        begin
            tgt = hit_idx_reg;
        end
        else if (free_found_reg)
        begin
            tgt = (evict && old_idx_reg < free_idx_reg) ? old_idx_reg : free_idx_reg;
        end
        else
        begin
            tgt = old_idx_reg;
        end
        new_map = (job_reg.msg_frags >= 7'd64) ? '1
                  : ((64'd1 << job_reg.msg_frags) - 64'd1);
        cur_map = hit_reg ? hit_map_reg : new_map;
        dup     = !cur_map[job_reg.frag_bit];
        upd_map = cur_map & ~(64'd1 << job_reg.frag_bit);
        chunk_bits = res_reg.missing_bits[{chunk_reg, 3'd0} +: 8];

        state_next      = state_reg;
        valid_next      = valid_reg;
        id_next         = id_reg;
        total_next      = total_reg;
        map_next        = map_reg;
        touch_next      = touch_reg;
        rank_next       = rank_reg;
        in_use_next     = in_use_reg;
        job_next        = job_reg;
        res_next        = res_reg;
        idx_next        = idx_reg;
        larger_next     = larger_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_total_next  = hit_total_reg;
        hit_map_next    = hit_map_reg;
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        old_time_next   = old_time_reg;
        old_rank_next   = old_rank_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        chunk_next      = chunk_reg;
        job_pop         = 1'b0;
        res_push        = 1'b0;
        v_after         = 1'b0;
        rk              = '0;

        case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop  = 1'b1;
                    job_next = job;
                    res_next = '0;
                    if (job.status != ST_NEW)
                    begin
                        res_next.status = job.status;
                        state_next      = B_OUT;
                    end
                    else
                    begin
                        idx_next        = '0;
                        larger_next     = '0;
                        hit_next        = 1'b0;
                        old_found_next  = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = B_WALK;
                    end
                end
            end
            B_WALK:
            begin
                if (valid_reg[idx_reg])
                begin
                    if (id_reg[idx_reg] > job_reg.message_id)
                    begin
                        larger_next = larger_reg + 1'b1;
                    end
                    if (id_reg[idx_reg] == job_reg.message_id)
                    begin
                        hit_next       = 1'b1;
                        hit_idx_next   = idx_reg;
                        hit_total_next = total_reg[idx_reg];
                        hit_map_next   = map_reg[idx_reg];
                    end
                    // oldest touch wins; on a tie the lower rank (newer entry)
                    if (!old_found_reg || touch_reg[idx_reg] < old_time_reg
                        || (touch_reg[idx_reg] == old_time_reg
                            && rank_reg[idx_reg] < old_rank_reg))
                    begin
                        old_found_next = 1'b1;
                        old_idx_next   = idx_reg;
                        old_time_next  = touch_reg[idx_reg];
                        old_rank_next  = rank_reg[idx_reg];
                    end
                end
                else if (!free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (idx_reg == IW'(TABLE_DEPTH - 1))
                begin
                    state_next = B_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            B_DECIDE:
            begin
                if (hit_reg && hit_total_reg != job_reg.message_bytes)
                begin
                    res_next.status = ST_SIZE;
                    state_next      = B_OUT;
                end
                else if (!hit_reg && job_reg.too_many)
                begin
                    res_next.status = ST_TOO_MANY;
                    state_next      = B_OUT;
                end
                else
                begin
                    if (!hit_reg)
                    begin
                        for (int k = 0; k < TABLE_DEPTH; k++)
                        begin
                            v_after = valid_reg[k] && !(evict && IW'(k) == old_idx_reg);
                            rk = rank_reg[k];
                            if (evict && valid_reg[k] && rank_reg[k] > old_rank_reg)
                            begin
                                rk = rk - 1'b1;
                            end
                            if (v_after)
                            begin
                                rk = rk + 1'b1;
                            end
                            rank_next[k]  = rk;
                            valid_next[k] = v_after;
                        end
                        valid_next[tgt] = 1'b1;
                        rank_next[tgt]  = '0;
                        id_next[tgt]    = job_reg.message_id;
                        total_next[tgt] = job_reg.message_bytes;
                        touch_next[tgt] = job_reg.now_time;
                        in_use_next     = in_use_reg - CW'(evict) + 1'b1;
                    end
                    map_next[tgt] = upd_map;
                    if (!dup)
                    begin
                        touch_next[tgt] = job_reg.now_time;
                    end
                    res_next.status        = dup ? ST_DUP : ST_NEW;
                    res_next.complete      = !dup && (upd_map == '0);
                    res_next.ack_now       = dup || (upd_map == '0)
                        || ((32'(larger_reg) + job_reg.message_id)
                            == {16'd0, job_reg.frag_count});
                    res_next.missing_bits  = upd_map;
                    res_next.missing_count = '0;
                    res_next.ack_id        = job_reg.message_id;
                    chunk_next             = '0;
                    state_next             = B_COUNT;
                end
            end
            B_COUNT:
            begin
                res_next.missing_count = res_reg.missing_count + {3'd0, pop8(chunk_bits)};
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == 3'd7)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            valid_reg  <= '0;
            in_use_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            in_use_reg <= in_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg         <= id_next;
        total_reg      <= total_next;
        map_reg        <= map_next;
        touch_reg      <= touch_next;
        rank_reg       <= rank_next;
        job_reg        <= job_next;
        res_reg        <= res_next;
        idx_reg        <= idx_next;
        larger_reg     <= larger_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_total_reg  <= hit_total_next;
        hit_map_reg    <= hit_map_next;
        old_found_reg  <= old_found_next;
        old_idx_reg    <= old_idx_next;
        old_time_reg   <= old_time_next;
        old_rank_reg   <= old_rank_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        chunk_reg      <= chunk_next;
    end

`ifndef SYNTHESIS
    a_in_use_matches: assert property (@(posedge clk) disable iff (!rst_n)
        in_use_reg == CW'($countones(valid_reg)))
        else $error("entry count out of step with valid bits");

    a_in_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_use_reg <= CW'(TABLE_DEPTH))
        else $error("entry count past table depth");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_reg.status > ST_DUP) |->
            (res_reg.missing_bits == '0 && !res_reg.ack_now && !res_reg.complete))
        else $error("error word carries table data");

    a_new_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DECIDE && state_next == B_COUNT && !hit_reg) |=>
            valid_reg[$past(tgt)])
        else $error("created entry not marked valid");
`endif

endmodule

// ===== design/fragment_reassembly_tracker.sv =====
// fragment_reassembly_tracker: top level; configuration registers, front,
// job queue, back and result queue. Uses frt_pkg, frt_front, frt_fifo, frt_back.
//
//   channel   direction  handshake           payload
//   frag      in         push / full         frag_t
//   result    out        pop / empty         result_t
//   config    in         cfg_we              cfg_index, cfg_data
//
// A header-checked item is divided bit-serially by the payload size in the
// front; the back walks the table, then updates the entry and counts the
// bitmap. Error items skip the remaining steps. Front and back overlap through the
// job queue. Reset clears the table's valid bits at once; no clearing pass.
// full stays high while the front holds an item; a stalled result queue
// backs up into the back and then the front.
module fragment_reassembly_tracker
    import frt_pkg::*;
#(
    parameter int TABLE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  frag_t       frag,
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    logic [15:0] mtu_reg;
    logic [3:0]  max_msg_reg;

    logic    job_push, job_full, job_pop, job_empty;
    job_t    job_in, job_out;
    logic    res_push, res_full;
    result_t res_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg     <= 16'd1024;
            max_msg_reg <= 4'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MTU:     mtu_reg     <= cfg_data;
                REG_MAX_MSG: max_msg_reg <= cfg_data[3:0];
                default:     mtu_reg     <= mtu_reg;
            endcase
        end
    end

    frt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mtu_bytes (mtu_reg),
        .push      (push),
        .full      (full),
        .frag      (frag),
        .job_full  (job_full),
        .job_push  (job_push),
        .job       (job_in)
    );

    frt_fifo #(.T(job_t), .DEPTH(2)) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .full  (job_full),
        .din   (job_in),
        .pop   (job_pop),
        .empty (job_empty),
        .dout  (job_out)
    );

    frt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_messages (max_msg_reg),
        .job_empty    (job_empty),
        .job_pop      (job_pop),
        .job          (job_out),
        .res_full     (res_full),
        .res_push     (res_push),
        .res          (res_in)
    );

    frt_fifo #(.T(result_t), .DEPTH(2)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .din   (res_in),
        .pop   (pop),
        .empty (empty),
        .dout  (result)
    );

endmodule
